>>> design/byte_ring_buffer_burst_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring buffer burst core.
// Shared implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_BURST_CORE_MACROS_SVH
`define BYTE_RING_BUFFER_BURST_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("port check failed in the same cycle");

// Next-cycle implication, disabled while reset is held.
`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("port check failed in the following cycle");

`endif

>>> design/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Constants, types and helpers shared by the ring buffer controller and
// datapath.
// ----------------------------------------------------------------------------
package brb_pkg;

    // Storage geometry and burst limits.
    localparam int DEPTH     = 256;
    localparam int MAX_BURST = 8;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CAP_W     = PTR_W + 1;
    localparam int CNT_W     = 4;
    localparam int LANE_W    = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
    localparam int BYTES_W   = 8 * MAX_BURST;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic wr_step;
        logic rd_step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_write;
        logic start_read;
        logic last_step;
        logic out_free;
    } t_status;

    // Clamp a capacity write to the range the storage supports.
    function automatic logic [CAP_W-1:0] clamp_capacity(input logic [CAP_W-1:0] v);
        logic [CAP_W-1:0] c;
        c = v;
        if (c < CAP_W'(2)) begin
            c = CAP_W'(2);
        end
        if (c > CAP_W'(DEPTH)) begin
            c = CAP_W'(DEPTH);
        end
        return c;
    endfunction

endpackage

>>> design/byte_ring_buffer_burst_core.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst_core
// Byte ring buffer with run-time capacity, taking write and read bursts of
// up to eight bytes.
// ----------------------------------------------------------------------------
// One request is in work at a time. The storage has one byte write port and
// one byte read port, so a burst moves one byte per cycle: an accepted write
// steps through the write and response states, an accepted read through the
// read, drain (for the registered read) and response states, and a refused or
// empty burst goes straight to the response state. The next request is taken
// once the result sits in the output register, even while that result is
// stalled. The capacity port is always ready; a write clears both pointers and
// must only be made while the buffer has no request in work.
// ----------------------------------------------------------------------------
module byte_ring_buffer_burst_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [brb_pkg::CNT_W-1:0]       i_count,
    input  logic [brb_pkg::BYTES_W-1:0]     i_wr_bytes,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_accepted,
    output logic [brb_pkg::BYTES_W-1:0]     o_rd_bytes,
    output logic [7:0]                      o_free_space,
    output logic [7:0]                      o_fill_level,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [brb_pkg::CAP_W-1:0]       i_cfg_data
);
    import brb_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The capacity register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    brb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Storage, pointers and output register.
    brb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_kind),
        .i_count      (i_count),
        .i_wr_bytes   (i_wr_bytes),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_accepted   (o_accepted),
        .o_rd_bytes   (o_rd_bytes),
        .o_free_space (o_free_space),
        .o_fill_level (o_fill_level)
    );

endmodule

>>> design/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Burst sequencer: takes a request, steps the datapath one byte per cycle
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  brb_pkg::t_status i_status,
    output brb_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);
    import brb_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.start_write) begin
                        n_state = S_WRITE;
                    end else if (i_status.start_read) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_WRITE: begin
                if (i_status.last_step) begin
                    n_state = S_RESP;
                end
            end
            S_READ: begin
                if (i_status.last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            S_WRITE: begin
                o_cmd.wr_step = 1'b1;
            end
            S_READ: begin
                o_cmd.rd_step = 1'b1;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_RESP: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> design/brb_datapath.sv
// ----------------------------------------------------------------------------
// brb_datapath
// Byte storage, ring pointers, fill counter, capacity register and the
// output register of the ring buffer.
// ----------------------------------------------------------------------------
module brb_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  brb_pkg::t_cmd                   i_cmd,
    output brb_pkg::t_status                o_status,
    input  logic                            i_kind,
    input  logic [brb_pkg::CNT_W-1:0]       i_count,
    input  logic [brb_pkg::BYTES_W-1:0]     i_wr_bytes,
    input  logic                            i_cfg_valid,
    input  logic [brb_pkg::CAP_W-1:0]       i_cfg_data,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic                            o_accepted,
    output logic [brb_pkg::BYTES_W-1:0]     o_rd_bytes,
    output logic [7:0]                      o_free_space,
    output logic [7:0]                      o_fill_level
);
    import brb_pkg::*;

    logic [7:0]         mem [DEPTH];
    logic [7:0]         r_q;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_fill;
    logic [CAP_W-1:0]   r_cap;
    logic               r_ok;
    logic [CNT_W-1:0]   r_count;
    logic [LANE_W-1:0]  r_idx;
    logic [LANE_W-1:0]  r_cap_idx;
    logic               r_cap_vld;
    logic [BYTES_W-1:0] r_wdata;
    logic [BYTES_W-1:0] r_rdata;
    logic               r_out_valid;
    logic               r_out_acc;
    logic [BYTES_W-1:0] r_out_rd;
    logic [7:0]         r_out_free;
    logic [7:0]         r_out_fill;

    logic [CAP_W-1:0]   free_now;
    logic               count_ok;
    logic               ok_in;
    logic [CAP_W-1:0]   rd_inc;
    logic [CAP_W-1:0]   wr_inc;
    logic [PTR_W-1:0]   rd_next;
    logic [PTR_W-1:0]   wr_next;

    // Space check for the request on the input.
    always_comb begin
        free_now = r_cap - CAP_W'(1) - {1'b0, r_fill};
        count_ok = (i_count <= CNT_W'(MAX_BURST));
        if (i_kind) begin
            ok_in = count_ok && ({1'b0, r_fill} >= CAP_W'(i_count));
        end else begin
            ok_in = count_ok && (free_now >= CAP_W'(i_count));
        end
    end

    // Pointer advance with wrap at the capacity.
    always_comb begin
        rd_inc  = {1'b0, r_rd_ptr} + CAP_W'(1);
        wr_inc  = {1'b0, r_wr_ptr} + CAP_W'(1);
        rd_next = (rd_inc >= r_cap) ? '0 : rd_inc[PTR_W-1:0];
        wr_next = (wr_inc >= r_cap) ? '0 : wr_inc[PTR_W-1:0];
    end

    // Status to the controller.
    always_comb begin
        o_status.start_write = ok_in && !i_kind && (i_count != '0);
        o_status.start_read  = ok_in && i_kind && (i_count != '0);
        o_status.last_step   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    // Byte storage: one write and one registered read each cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_step) begin
            mem[r_wr_ptr] <= r_wdata[7:0];
        end
        r_q <= mem[r_rd_ptr];
    end

    // Capacity, pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= clamp_capacity(CAP_W'(DEPTH));
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_fill   <= '0;
        end else if (i_cfg_valid) begin
            r_cap    <= clamp_capacity(i_cfg_data);
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_fill   <= '0;
        end else if (i_cmd.wr_step) begin
            r_wr_ptr <= wr_next;
            r_fill   <= r_fill + PTR_W'(1);
        end else if (i_cmd.rd_step) begin
            r_rd_ptr <= rd_next;
            r_fill   <= r_fill - PTR_W'(1);
        end
    end

    // Request registers and byte lanes.
    always_ff @(posedge i_clk) begin
        r_cap_vld <= i_cmd.rd_step;
        r_cap_idx <= r_idx;
        if (i_cmd.load_in) begin
            r_ok    <= ok_in;
            r_count <= i_count;
            r_idx   <= '0;
            r_wdata <= i_wr_bytes;
            r_rdata <= '0;
        end else begin
            if (i_cmd.wr_step) begin
                r_wdata <= r_wdata >> 8;
            end
            if (i_cmd.wr_step || i_cmd.rd_step) begin
                r_idx <= r_idx + LANE_W'(1);
            end
            if (r_cap_vld) begin
                r_rdata[8*r_cap_idx +: 8] <= r_q;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_acc  <= r_ok;
            r_out_rd   <= r_rdata;
            r_out_free <= free_now[7:0];
            r_out_fill <= r_fill;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_accepted   = r_out_acc;
    assign o_rd_bytes   = r_out_rd;
    assign o_free_space = r_out_free;
    assign o_fill_level = r_out_fill;

endmodule

>>> design/brb_checker.sv
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks for the byte ring buffer burst core, bound to the top.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_burst_core_macros.svh"

module brb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic                            o_accepted,
    input logic [brb_pkg::BYTES_W-1:0]     o_rd_bytes,
    input logic [7:0]                      o_free_space,
    input logic [7:0]                      o_fill_level
);
    import brb_pkg::*;

    // A stalled result stays on offer.
    `BRB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A refused burst returns no read data.
    `BRB_ASSERT_NOW(a_refused_zero, i_clk, i_rst_n, o_out_valid && !o_accepted, o_rd_bytes == '0)

    // Free space and fill level never exceed one less than the largest ring.
    `BRB_ASSERT_NOW(a_level_sum, i_clk, i_rst_n, o_out_valid, ({1'b0, o_free_space} + {1'b0, o_fill_level}) <= 9'd255)

    // Only one request is in work: the input stalls straight after a request.
    `BRB_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind byte_ring_buffer_burst_core brb_checker u_brb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_accepted   (o_accepted),
    .o_rd_bytes   (o_rd_bytes),
    .o_free_space (o_free_space),
    .o_fill_level (o_fill_level)
);
